/* rtl/core/tdcb_pkg.sv */
// Package for the tile deduplication character-set builder.
// Holds the table geometry, register indexes, payload and control structs.
// No dependencies.
package tdcb_pkg;

    localparam int TABLE_DEPTH = 128;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int PAT_W       = 48;
    localparam int CODE_W      = 8;
    localparam int TIDX_W      = 7;
    localparam int CFG_W       = 8;
    localparam int CFG_IDX_W   = 1;
    localparam int CMP_W       = (IDX_W > CODE_W) ? IDX_W : CODE_W;

    localparam logic [CFG_IDX_W-1:0] CFG_CHAR_LIMIT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_CODE  = 1'b1;

    localparam logic [CFG_W-1:0] CHAR_LIMIT_RST = 8'd96;
    localparam logic [CFG_W-1:0] BASE_CODE_RST  = 8'd32;

    typedef struct packed {
        logic [PAT_W-1:0] tile_pattern;
        logic             image_start;
    } tile_in_t;

    typedef struct packed {
        logic [CODE_W-1:0] char_code;
        logic [TIDX_W-1:0] tile_index;
        logic              is_new;
        logic              table_full;
    } tile_out_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic scan;
        logic finish;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic decided;
        logic out_free;
    } dp_stat_t;

    // Indexes at or above the limit map to the blank code (base_code itself).
    function automatic logic [CODE_W-1:0] make_code(
        input logic [IDX_W-1:0]  index,
        input logic [CFG_W-1:0]  limit,
        input logic [CODE_W-1:0] base
    );
        logic [CMP_W-1:0] idx_ext;
        logic [CMP_W-1:0] lim_ext;
        logic [CMP_W-1:0] sum;
        idx_ext = CMP_W'(index);
        lim_ext = CMP_W'(limit);
        sum     = CMP_W'(base) + idx_ext;
        if (idx_ext >= lim_ext)
            return base;
        return sum[CODE_W-1:0];
    endfunction

endpackage

/* rtl/core/tdcb_ctrl.sv */
// Controller state machine of the tile deduplication character-set builder.
// Sequences accept, table scan and result write. Depends on tdcb_pkg.
module tdcb_ctrl
    import tdcb_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_SCAN = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (stat.decided)
                begin
                    // Hold the decision until the output register can take the word.
                    if (stat.out_free)
                    begin
                        cmd.finish = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    cmd.scan = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

/* rtl/core/tdcb_datapath.sv */
// Datapath of the tile deduplication character-set builder: pattern table,
// scan pointer, entry count, configuration and output register. Uses tdcb_pkg.
module tdcb_datapath
    import tdcb_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  tile_in_t             in_data,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  dp_cmd_t              cmd,
    output dp_stat_t             stat,
    output logic                 out_valid,
    input  logic                 out_ready,
    output tile_out_t            out_data
);

    logic [PAT_W-1:0] mem [TABLE_DEPTH];

    logic [PAT_W-1:0]  pat_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  ptr_reg;
    logic [PAT_W-1:0]  rd_data_reg;
    logic [IDX_W-1:0]  rd_idx_reg;
    logic              rd_vld_reg;
    logic [CFG_W-1:0]  char_limit_reg;
    logic [CODE_W-1:0] base_code_reg;
    logic              out_valid_reg;
    tile_out_t         out_data_reg;
    tile_out_t         out_data_next;

    logic scan_more;
    logic hit;
    logic has_room;

    assign scan_more = (ptr_reg < count_reg);
    assign hit       = rd_vld_reg && (rd_data_reg == pat_reg);
    assign has_room  = (count_reg < CNT_W'(TABLE_DEPTH));

    assign stat.decided  = hit || (!scan_more && !rd_vld_reg);
    assign stat.out_free = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        out_data_next = '0;
        priority if (hit)
        begin
            out_data_next.char_code  = make_code(rd_idx_reg, char_limit_reg, base_code_reg);
            out_data_next.tile_index = TIDX_W'(rd_idx_reg);
        end
        else if (has_room)
        begin
            out_data_next.char_code  = make_code(count_reg[IDX_W-1:0], char_limit_reg,
                                                 base_code_reg);
            out_data_next.tile_index = TIDX_W'(count_reg[IDX_W-1:0]);
            out_data_next.is_new     = 1'b1;
        end
        else
        begin
            out_data_next.char_code  = base_code_reg;
            out_data_next.table_full = 1'b1;
        end
    end

    // Table storage: one read per scan cycle, one write when a miss is appended.
    always_ff @(posedge clk)
    begin
        if (cmd.scan)
            rd_data_reg <= mem[ptr_reg[IDX_W-1:0]];
        if (cmd.finish && !hit && has_room)
            mem[count_reg[IDX_W-1:0]] <= pat_reg;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
            pat_reg <= in_data.tile_pattern;
        if (cmd.scan)
            rd_idx_reg <= ptr_reg[IDX_W-1:0];
        if (cmd.finish)
            out_data_reg <= out_data_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            ptr_reg        <= '0;
            rd_vld_reg     <= 1'b0;
            char_limit_reg <= CHAR_LIMIT_RST;
            base_code_reg  <= BASE_CODE_RST;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_CHAR_LIMIT: char_limit_reg <= cfg_data;
                    CFG_BASE_CODE:  base_code_reg  <= cfg_data;
                endcase
            end

            if (cmd.load)
            begin
                ptr_reg    <= '0;
                rd_vld_reg <= 1'b0;
                if (in_data.image_start)
                    count_reg <= '0;
            end
            else if (cmd.scan)
            begin
                rd_vld_reg <= scan_more;
                if (scan_more)
                    ptr_reg <= ptr_reg + CNT_W'(1);
            end

            if (cmd.finish && !hit && has_room)
                count_reg <= count_reg + CNT_W'(1);

            if (cmd.finish)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

endmodule

/* rtl/core/tile_dedup_charset_builder_unit.sv */
// Top level of the tile deduplication character-set builder.
// Joins tdcb_ctrl and tdcb_datapath; types and constants from tdcb_pkg.
// Usage:
//   The input channel (in_valid, in_ready, in_data) carries one word per
//   6x8 tile: a 48-bit pattern and an image_start flag that empties the
//   table of unique patterns before the tile is looked up. The output
//   channel (out_valid, out_ready, out_data) returns one word per tile: the
//   character code, the table index, a new-entry flag and a table-full flag.
//   The configuration port (cfg_we, cfg_index, cfg_data) writes char_limit
//   at index 0 and base_code at index 1; write it only while the block is idle.
// Timing:
//   A tile is compared against the stored patterns one entry per cycle. Its
//   result is registered once a match is found or all stored entries are
//   compared and the output register is free; a hit ends the scan early.
//   One tile is processed at a time; in_ready returns once that result is written.
// Reset:
//   Reset empties the table (the entry count goes to zero), restores
//   char_limit to 96 and base_code to 32, and drops out_valid. Table
//   contents are not cleared; entries at or beyond the count are never compared.
// Stalls:
//   A result waits in the output register until taken. The next tile may be
//   accepted meanwhile, and its result is held back until the register frees.
module tile_dedup_charset_builder_unit
    import tdcb_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  tile_in_t             in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output tile_out_t            out_data,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // The controller decides when to load, scan and write a result.
    tdcb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // The datapath holds the table, the counters and the output register.
    tdcb_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .stat      (stat),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

/* sim/tile_dedup_charset_builder_unit_test.sv */
// Testbench for tile_dedup_charset_builder_unit: random tiles and images are
// pushed through the valid/ready channels and each result word is checked
// against a cycle-free lookup model kept here. Depends on tdcb_pkg and the RTL.
`timescale 1ns / 100ps

module tile_dedup_charset_builder_unit_test
    import tdcb_pkg::*;
();

    // The limit sits well above the slowest correct run, with every tile
    // scanned in full plus input gaps and output stalls.
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int RANDOM_ITEMS = 1000;
    localparam int DRAIN_CYCLES = 8;
    localparam int REPORT_MAX   = 10;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    tile_in_t             in_data = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    tile_out_t            out_data;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_CHAR_LIMIT;
    logic [CFG_W-1:0]     cfg_data = '0;

    tile_dedup_charset_builder_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Our own copy of the unique-pattern table and the two registers. Only
    // entries below stored_count are ever looked at, just as in the block.
    logic [PAT_W-1:0] stored_tiles [TABLE_DEPTH];
    int unsigned      stored_count = 0;
    logic [CFG_W-1:0] limit_reg = CHAR_LIMIT_RST;
    logic [CFG_W-1:0] base_reg  = BASE_CODE_RST;

    // Result words predicted at input acceptance, oldest first.
    tile_out_t awaited_codes [$];

    // Percent chance of an idle cycle on the input side and of a stall on
    // the output side. Both are dropped to zero for the back-to-back test.
    int unsigned idle_pct  = 37;
    int unsigned stall_pct = 37;

    int unsigned fail_count  = 0;
    int unsigned cycle_count = 0;
    tile_out_t   want_word;

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Watchdog: a hung handshake ends the run here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic note_failure(input string msg);
        fail_count++;
        if (fail_count <= REPORT_MAX)
            $display("[%0t] %s", $realtime, msg);
    endtask

    // Text code for a table index: indexes at or above the limit get the
    // blank character, which is base_code itself; the sum wraps at 8 bits.
    function automatic logic [CODE_W-1:0] code_for(input int unsigned slot);
        logic [15:0] sum;
        sum = 16'(base_reg) + 16'(slot);
        if (slot >= int'(limit_reg))
            return base_reg;
        return sum[CODE_W-1:0];
    endfunction

    // Looks one tile up in the model table and updates it the way the block
    // should: a start tile empties the table, a miss appends if there is room.
    function automatic tile_out_t lookup_tile(input logic [PAT_W-1:0] pat,
                                              input logic start);
        tile_out_t   res;
        bit          hit;
        int unsigned slot;
        res  = '0;
        hit  = 1'b0;
        slot = 0;
        if (start)
            stored_count = 0;
        for (int unsigned i = 0; i < stored_count; i++)
        begin
            if (!hit && stored_tiles[i] == pat)
            begin
                hit  = 1'b1;
                slot = i;
            end
        end
        if (hit)
        begin
            res.char_code  = code_for(slot);
            res.tile_index = slot[TIDX_W-1:0];
        end
        else if (stored_count < TABLE_DEPTH)
        begin
            slot = stored_count;
            stored_tiles[slot] = pat;
            stored_count++;
            res.char_code  = code_for(slot);
            res.tile_index = slot[TIDX_W-1:0];
            res.is_new     = 1'b1;
        end
        else
        begin
            // No room left: the tile is not stored and comes back blank.
            res.char_code  = base_reg;
            res.table_full = 1'b1;
        end
        return res;
    endfunction

    function automatic logic [PAT_W-1:0] random_pattern();
        logic [63:0] w;
        w = {$urandom, $urandom};
        return w[PAT_W-1:0];
    endfunction

    // Sends one tile word. Random idle cycles come first with valid low; once
    // valid is raised it stays up with the same word until in_ready is seen.
    // Valid is left high on return so that a following word can go out in
    // the very next cycle without a drop.
    task automatic send_tile(input logic [PAT_W-1:0] pat, input logic start);
        tile_in_t  word;
        tile_out_t predicted;
        word.tile_pattern = pat;
        word.image_start  = start;
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= word;
        do
            @(posedge clk);
        while (!in_ready);
        predicted     = lookup_tile(pat, start);
        awaited_codes = {awaited_codes, predicted};
    endtask

    // Brings the block to rest: no word pending on input and every predicted
    // result taken before any register write.
    task automatic settle_idle();
        in_valid <= 1'b0;
        while (awaited_codes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        if (idx == CFG_CHAR_LIMIT)
            limit_reg = value;
        if (idx == CFG_BASE_CODE)
            base_reg = value;
    endtask

    task automatic set_codes(input logic [CFG_W-1:0] limit,
                             input logic [CFG_W-1:0] base);
        settle_idle();
        write_reg(CFG_CHAR_LIMIT, limit);
        write_reg(CFG_BASE_CODE, base);
    endtask

    // Output side: every result word taken is checked against the oldest
    // prediction, and out_ready is redrawn at random for the next cycle.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (awaited_codes.size() == 0)
            begin
                note_failure($sformatf("unexpected result word %h", out_data));
            end
            else
            begin
                want_word = awaited_codes.pop_front();
                if (out_data.char_code  !== want_word.char_code  ||
                    out_data.tile_index !== want_word.tile_index ||
                    out_data.is_new     !== want_word.is_new     ||
                    out_data.table_full !== want_word.table_full)
                    note_failure($sformatf(
                        "code/index/new/full expected %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                        want_word.char_code, want_word.tile_index,
                        want_word.is_new, want_word.table_full,
                        out_data.char_code, out_data.tile_index,
                        out_data.is_new, out_data.table_full));
            end
        end
        out_ready <= ($urandom_range(99) >= stall_pct);
    end

    // Hand-picked tiles under the reset codes, then the odd register values:
    // a limit of one, a limit of zero that blanks everything, and a base that
    // makes the code wrap past 255.
    task automatic test_directed();
        send_tile('0, 1'b1);
        send_tile('1, 1'b0);
        send_tile('0, 1'b0);
        send_tile(48'h8000_0000_0000, 1'b0);
        send_tile(48'h0000_0000_0001, 1'b0);
        send_tile('1, 1'b0);
        send_tile(48'hAAAA_AAAA_AAAA, 1'b0);
        send_tile(48'h5555_5555_5555, 1'b0);
        // A start tile always lands at index zero, even twice in a row.
        send_tile('1, 1'b1);
        send_tile('1, 1'b1);
        send_tile('0, 1'b0);

        set_codes(8'd1, 8'd255);
        send_tile(48'h0123_4567_89AB, 1'b1);
        send_tile(48'hFEDC_BA98_7654, 1'b0);
        send_tile(48'h0123_4567_89AB, 1'b0);

        set_codes(8'd0, 8'd0);
        send_tile(48'h0123_4567_89AB, 1'b1);
        send_tile(48'h0000_0000_0002, 1'b0);

        set_codes(8'd255, 8'd250);
        for (int i = 0; i < 8; i++)
            send_tile(48'h0F0F_0000_0000 | 48'(i), i == 0);
    endtask

    // Fills all 128 entries, then misses on a full table, hits the last
    // entry with a code that wraps, and empties it again with a start tile.
    task automatic test_table_full();
        logic [PAT_W-1:0] filled [$];
        logic [PAT_W-1:0] pat;
        set_codes(8'd128, 8'd200);
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            pat    = random_pattern();
            filled = {filled, pat};
            send_tile(pat, i == 0);
        end
        send_tile(random_pattern(), 1'b0);
        send_tile(filled[TABLE_DEPTH-1], 1'b0);
        send_tile(filled[0], 1'b0);
        send_tile(random_pattern(), 1'b0);
        send_tile(filled[5], 1'b1);
    endtask

    // A stretch with no input gaps and no output stalls at all.
    task automatic test_back_to_back();
        logic [PAT_W-1:0] palette [$];
        settle_idle();
        idle_pct  = 0;
        stall_pct = 0;
        repeat (12) palette = {palette, random_pattern()};
        for (int i = 0; i < 120; i++)
            send_tile(palette[$urandom_range(palette.size() - 1)], i % 40 == 0);
        settle_idle();
        idle_pct  = 37;
        stall_pct = 37;
    endtask

    // Random images: each starts with a start tile and repeats tiles from a
    // small palette, with near misses one pixel off and fresh tiles mixed
    // in. Now and then a long image of mostly fresh tiles runs the table
    // full. Codes are redrawn between some images.
    task automatic test_random_images();
        logic [PAT_W-1:0] palette [$];
        logic [PAT_W-1:0] pat;
        int unsigned      sent_count;
        int unsigned      img_len;
        int unsigned      fresh_pct;
        logic [CFG_W-1:0] limit;
        logic [CFG_W-1:0] base;
        sent_count = 0;
        while (sent_count < RANDOM_ITEMS)
        begin
            if ($urandom_range(5) == 0)
            begin
                case ($urandom_range(5))
                    0: limit = 8'd0;
                    1: limit = 8'd1;
                    2: limit = 8'd128;
                    3: limit = 8'd255;
                    default: limit = 8'($urandom_range(1, 128));
                endcase
                case ($urandom_range(3))
                    0: base = 8'd0;
                    1: base = 8'd255;
                    default: base = 8'($urandom_range(255));
                endcase
                set_codes(limit, base);
            end
            palette.delete();
            repeat ($urandom_range(1, 24)) palette = {palette, random_pattern()};
            if ($urandom_range(19) == 0)
            begin
                img_len   = $urandom_range(130, 160);
                fresh_pct = 90;
            end
            else
            begin
                img_len   = $urandom_range(4, 40);
                fresh_pct = 10;
            end
            for (int t = 0; t < img_len; t++)
            begin
                if ($urandom_range(99) < fresh_pct)
                begin
                    pat     = random_pattern();
                    palette = {palette, pat};
                end
                else if ($urandom_range(4) == 0)
                begin
                    pat = palette[$urandom_range(palette.size() - 1)]
                          ^ (48'h1 << $urandom_range(PAT_W - 1));
                end
                else
                begin
                    pat = palette[$urandom_range(palette.size() - 1)];
                end
                // Mostly one start per image, with a rare stray start.
                send_tile(pat, t == 0 || $urandom_range(49) == 0);
            end
            sent_count += img_len;
        end
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_table_full();
        test_back_to_back();
        test_random_images();

        settle_idle();
        repeat (20) @(posedge clk);
        if (fail_count == 0 && awaited_codes.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
